@@ rtl/core/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: request and result
// payloads, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int IDX_W        = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
    } skt_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             found;
        logic [IDX_W-1:0] count;
        logic [1:0]       status;
    } skt_rsp_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic     valid;
        skt_rsp_t data;
    } skt_done_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// an add moves larger entries up one slot and then writes its key; a refused add and
// the unused code finish at once; find and delete binary-search with at most
// log2(count)+1 probes, and a delete hit then moves the later entries down one slot
// throughput: one request at a time; the next is taken once the result sits in the
// output register, set by the single RAM read port and the shared key comparator
// reset: sync active-low aresetn empties the table and clears output valid; keys stay
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted key table with binary search over a key RAM, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire skt_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output skt_rsp_t      m_data
);

    localparam int AW = $clog2(CAPACITY);

    skt_done_t        done;
    logic             out_free;
    logic             ram_wr_en, ram_rd_en;
    logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
    logic [KEY_W-1:0] ram_wr_data, ram_rd_data;

    logic     m_valid_reg, m_valid_next;
    skt_rsp_t m_data_reg, m_data_next;

    skt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    skt_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .done        (done),
        .out_free    (out_free),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done.valid && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = done.data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a taken request always moves the sequencer out of its ready state
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer still ready after taking a request");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.count == IDX_W'(CAPACITY))
        else $error("full status with table not at capacity");

    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.status == ST_DONE)
        else $error("match reported with non-done status");

    a_add_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.index == '0 && !m_data.found)
        else $error("refused add reports an index");

endmodule

`default_nettype wire

@@ rtl/core/skt_ram.sv @@
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/skt_engine.sv @@
// ----------------------------------------------------------------------------
// skt_engine
// Sequencer of the sorted key table: insertion shift, binary search and
// delete shift over the key RAM; the first two share one key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_engine
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire skt_req_t                    s_data,
    output skt_done_t                        done,
    input  wire logic                        out_free,
    output logic                             ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
    output logic [KEY_W-1:0]                 ram_wr_data,
    output logic                             ram_rd_en,
    output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
    input  wire logic [KEY_W-1:0]            ram_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ADD_RD   = 8'b0000_0010,
        S_ADD_CMP  = 8'b0000_0100,
        S_SRCH_RD  = 8'b0000_1000,
        S_SRCH_CMP = 8'b0001_0000,
        S_DEL_RD   = 8'b0010_0000,
        S_DEL_WR   = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hx_reg, hx_next;     // exclusive upper bound of the search
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [1:0]       status_reg, status_next;

    // shared comparator: stored entry against the request key
    logic key_lt, key_eq, key_gt;
    assign key_lt = ram_rd_data < key_reg;
    assign key_eq = ram_rd_data == key_reg;
    assign key_gt = !key_lt && !key_eq;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW:0]   ptr_inc;
    logic [CW-1:0] ptr_dec;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hx_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[CW:1];
    assign ptr_inc = {1'b0, ptr_reg} + {{CW{1'b0}}, 1'b1};
    assign ptr_dec = ptr_reg - {{(CW-1){1'b0}}, 1'b1};

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hx_next     = hx_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg[AW-1:0];
        ram_wr_data = key_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_dec[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data.operation;
                    key_next    = s_data.key;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_DONE;
                    lo_next     = '0;
                    hx_next     = count_reg;
                    ptr_next    = count_reg;
                    unique case (s_data.operation) inside
                        OP_ADD: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end else begin
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_FIND, OP_DELETE: state_next = S_SRCH_RD;
                        default:            state_next = S_FIN;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (ptr_reg == '0) begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_FIN;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                ram_wr_en = 1'b1;
                if (key_gt) begin
                    // larger entry moves up one slot
                    ram_wr_data = ram_rd_data;
                    ptr_next    = ptr_dec;
                    state_next  = S_ADD_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SRCH_RD: begin
                if (lo_reg >= hx_reg) begin
                    idx_next    = count_reg;
                    status_next = ST_MISSING;
                    state_next  = S_FIN;
                end else begin
                    ptr_next    = mid;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid[AW-1:0];
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (key_eq) begin
                    idx_next   = ptr_reg;
                    found_next = 1'b1;
                    state_next = (op_reg == OP_DELETE) ? S_DEL_RD : S_FIN;
                end else if (key_lt) begin
                    lo_next    = ptr_inc[CW-1:0];
                    state_next = S_SRCH_RD;
                end else begin
                    hx_next    = ptr_reg;
                    state_next = S_SRCH_RD;
                end
            end
            S_DEL_RD: begin
                if (ptr_inc >= {1'b0, count_reg}) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FIN;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_inc[AW-1:0];
                    state_next  = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
                ptr_next    = ptr_inc[CW-1:0];
                state_next  = S_DEL_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hx_reg     <= hx_next;
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign s_ready           = state_reg == S_IDLE;
    assign done.valid        = state_reg == S_FIN;
    assign done.data.index   = IDX_W'(idx_reg);
    assign done.data.found   = found_reg;
    assign done.data.count   = IDX_W'(count_reg);
    assign done.data.status  = status_reg;

endmodule

`default_nettype wire

@@ tb/skt_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skt_result_checker
// Watches both channels of the sorted key table, keeps its own sorted copy of
// the stored keys, predicts one result per request and compares each result.
// ----------------------------------------------------------------------------

module skt_result_checker
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  skt_req_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  skt_rsp_t    m_data,
    output int unsigned outstanding,
    output int unsigned mismatch_count
);

    logic [KEY_W-1:0] table_keys [CAPACITY];
    int               key_total;
    skt_rsp_t         pending_rsp [$];
    int unsigned      fails;
    int unsigned      rsp_seen;

    // applies one request to the local table and returns its result
    function automatic skt_rsp_t table_step(skt_req_t req);
        skt_rsp_t rsp;
        int       pos;
        int       lo;
        int       hi;
        int       mid;
        int       hit;
        rsp        = '0;
        rsp.status = ST_DONE;
        case (req.operation) inside
            OP_ADD: begin
                if (key_total >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    // equal keys stay ahead of the new one
                    pos = key_total;
                    while (pos > 0 && table_keys[pos-1] > req.key) begin
                        table_keys[pos] = table_keys[pos-1];
                        pos--;
                    end
                    table_keys[pos] = req.key;
                    key_total++;
                end
            end
            OP_FIND, OP_DELETE: begin
                lo  = 0;
                hi  = key_total - 1;
                hit = -1;
                while (hit < 0 && lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (table_keys[mid] == req.key) begin
                        hit = mid;
                    end else if (table_keys[mid] < req.key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                if (hit < 0) begin
                    rsp.index  = IDX_W'(key_total);
                    rsp.status = ST_MISSING;
                end else begin
                    rsp.index = IDX_W'(hit);
                    rsp.found = 1'b1;
                    if (req.operation == OP_DELETE) begin
                        for (pos = hit; pos + 1 < key_total; pos++) begin
                            table_keys[pos] = table_keys[pos+1];
                        end
                        key_total--;
                    end
                end
            end
            default: ;
        endcase
        rsp.count = IDX_W'(key_total);
        return rsp;
    endfunction

    always @(posedge aclk) begin
        skt_rsp_t want;
        if (!aresetn) begin
            key_total = 0;
            fails     = 0;
            rsp_seen  = 0;
            pending_rsp.delete();
        end else begin
            if (m_valid && m_ready) begin
                rsp_seen++;
                if (pending_rsp.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display(
                            "result %0d with no request pending: %0d %0d %0d %0d",
                            rsp_seen, m_data.index, m_data.found, m_data.count,
                            m_data.status);
                    end
                end else begin
                    want = pending_rsp.pop_front();
                    if (m_data.index !== want.index || m_data.found !== want.found ||
                        m_data.count !== want.count || m_data.status !== want.status) begin
                        fails++;
                        if (fails <= 10) begin
                            $display(
                                "result %0d: index %0d/%0d found %0d/%0d (exp/got)",
                                rsp_seen, want.index, m_data.index, want.found,
                                m_data.found);
                            $display(
                                "result %0d: count %0d/%0d status %0d/%0d (exp/got)",
                                rsp_seen, want.count, m_data.count, want.status,
                                m_data.status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_rsp.push_back(table_step(s_data));
            end
        end
        outstanding    <= pending_rsp.size();
        mismatch_count <= fails;
    end

endmodule

@@ tb/sorted_key_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Drives add, find, delete and unused-code requests into the sorted key
// table: a directed opening, then phases that fill, mix and drain the table
// with keys reused from earlier adds, under random gaps on both channels.
// ----------------------------------------------------------------------------

module sorted_key_table_tb
    import skt_pkg::*;
();

    localparam int          RANDOM_ITEMS = 1300;
    localparam int          PHASE_LEN    = 130;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 300;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    skt_req_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    skt_rsp_t    m_data;
    logic        steady;
    int unsigned outstanding;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    logic [KEY_W-1:0] live_keys [$];

    always #5 aclk = ~aclk;

    sorted_key_table i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    skt_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_key_table: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4, 5, 6: return KEY_W'($urandom_range(24, 1));
            default: return $urandom();
        endcase
    endfunction

    // holds the request until accepted, after an optional random gap
    task automatic issue(input logic [1:0] op, input logic [KEY_W-1:0] key);
        skt_req_t req;
        req.operation = op;
        req.key       = key;
        while (!steady && $urandom_range(99) < 32) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int unsigned      roll;
        int unsigned      add_pct;
        int unsigned      find_pct;
        int unsigned      del_pct;
        int               pick;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        steady       = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // empty table, extremes, duplicates, misses, unused code
        issue(OP_FIND,   32'd5);
        issue(OP_DELETE, 32'd5);
        issue(OP_ADD,    32'h0000_0000);
        issue(OP_ADD,    32'hFFFF_FFFF);
        issue(OP_ADD,    32'h0000_0001);
        issue(OP_ADD,    32'h0000_0001);
        issue(OP_ADD,    32'h8000_0000);
        issue(OP_ADD,    32'h0000_0007);
        issue(OP_FIND,   32'h0000_0000);
        issue(OP_FIND,   32'hFFFF_FFFF);
        issue(OP_FIND,   32'h0000_0001);
        issue(OP_FIND,   32'h0000_0006);
        issue(OP_DELETE, 32'h0000_0001);
        issue(OP_DELETE, 32'h0000_0001);
        issue(OP_DELETE, 32'h0000_0001);
        issue(OP_DELETE, 32'hFFFF_FFFF);
        issue(OP_UNUSED, 32'h5A5A_A5A5);
        issue(OP_FIND,   32'h8000_0000);
        issue(OP_DELETE, 32'h0000_0000);
        issue(OP_FIND,   32'h7FFF_FFFF);

        // fill, mix, drain, mix; reuse of added keys makes hits likely
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 500 && n < 700);
            case ((n / PHASE_LEN) % 4)
                0: begin
                    add_pct = 85; find_pct = 8;  del_pct = 5;
                end
                2: begin
                    add_pct = 10; find_pct = 20; del_pct = 68;
                end
                default: begin
                    add_pct = 40; find_pct = 30; del_pct = 28;
                end
            endcase
            roll = $urandom_range(99);
            if (roll < add_pct) begin
                op = OP_ADD;
            end else if (roll < add_pct + find_pct) begin
                op = OP_FIND;
            end else if (roll < add_pct + find_pct + del_pct) begin
                op = OP_DELETE;
            end else begin
                op = OP_UNUSED;
            end
            key  = fresh_key();
            pick = -1;
            if (op != OP_ADD && live_keys.size() > 0 && $urandom_range(99) < 75) begin
                pick = $urandom_range(live_keys.size() - 1);
                key  = live_keys[pick];
            end
            if (op == OP_ADD && live_keys.size() < CAPACITY_DEF) begin
                live_keys.push_back(key);
            end else if (op == OP_DELETE && pick >= 0) begin
                live_keys.delete(pick);
            end
            issue(op, key);
        end
        s_valid = 1'b0;
        steady  = 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sorted_key_table: match");
        end else begin
            $display("sorted_key_table: mismatch");
        end
        $finish;
    end

endmodule

@@ sorted_key_table.f @@
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_engine.sv
rtl/core/sorted_key_table.sv
tb/skt_result_checker.sv
tb/sorted_key_table_tb.sv
